@@ hw/rtl/int64_divide_modulo_macros.svh @@
// ----------------------------------------------------------------------------
// int64_divide_modulo assertion macros
// Shared concurrent assertion forms for the divider modules.
// ----------------------------------------------------------------------------
`ifndef INT64_DIVIDE_MODULO_MACROS_SVH
`define INT64_DIVIDE_MODULO_MACROS_SVH

// Condition and consequence in the same cycle.
`define IDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define IDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/idm_pkg.sv @@
// ----------------------------------------------------------------------------
// idm_pkg
// Widths and the stage record shared by the pipelined divider.
// ----------------------------------------------------------------------------
package idm_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int NUM_CELLS  = DATA_WIDTH;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] partial;
        logic [DATA_WIDTH-1:0] shift;
        logic [DATA_WIDTH-1:0] divisor;
        logic                  neg_quo;
        logic                  neg_rem;
        logic                  div_zero;
    } idm_stage_t;

endpackage

@@ hw/rtl/idm_req_if.sv @@
// ----------------------------------------------------------------------------
// idm_req_if
// Operand channel of the divider: mode bit, dividend and divisor.
// ----------------------------------------------------------------------------
interface idm_req_if
    import idm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output command, output dividend, output divisor,
                    input ready);
    modport sink (input valid, input command, input dividend, input divisor,
                  output ready);
endinterface

@@ hw/rtl/idm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// idm_rsp_if
// Result channel of the divider: quotient, remainder and zero-divisor flag.
// ----------------------------------------------------------------------------
interface idm_rsp_if
    import idm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
    logic                  divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

@@ hw/rtl/idm_pre.sv @@
// ----------------------------------------------------------------------------
// idm_pre
// Input stage: takes operand magnitudes, records the result signs, flags zero divisor.
// ----------------------------------------------------------------------------
module idm_pre
    import idm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    idm_req_if.sink    req,
    output logic       valid_out,
    input  logic       ready_in,
    output idm_stage_t stage_out
);

    logic       valid_reg;
    logic       valid_next;
    logic       ready_out;
    logic       neg_a;
    logic       neg_b;
    idm_stage_t stage_reg;
    idm_stage_t stage_next;

    always_comb
    begin
        neg_a = req.command & req.dividend[DATA_WIDTH-1];
        neg_b = req.command & req.divisor[DATA_WIDTH-1];
        stage_next.partial  = '0;
        stage_next.shift    = neg_a ? ('0 - req.dividend) : req.dividend;
        stage_next.divisor  = neg_b ? ('0 - req.divisor) : req.divisor;
        stage_next.neg_quo  = neg_a ^ neg_b;
        stage_next.neg_rem  = neg_a;
        stage_next.div_zero = (req.divisor == '0);
    end

    assign ready_out  = !valid_reg || ready_in;
    assign valid_next = ready_out ? req.valid : valid_reg;
    assign req.ready  = ready_out;
    assign valid_out  = valid_reg;
    assign stage_out  = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && ready_out)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ hw/rtl/idm_cell.sv @@
// ----------------------------------------------------------------------------
// idm_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`include "int64_divide_modulo_macros.svh"

module idm_cell
    import idm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid_in,
    output logic       ready_out,
    input  idm_stage_t stage_in,
    output logic       valid_out,
    input  logic       ready_in,
    output idm_stage_t stage_out
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  carry;
    logic                  take;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    idm_stage_t            stage_reg;
    idm_stage_t            stage_next;

    always_comb
    begin
        carry   = stage_in.partial[DATA_WIDTH-1];
        shifted = {stage_in.partial[DATA_WIDTH-2:0], stage_in.shift[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, stage_in.divisor};
        take    = carry | ~diff[DATA_WIDTH];
        stage_next         = stage_in;
        stage_next.partial = take ? diff[DATA_WIDTH-1:0] : shifted;
        stage_next.shift   = {stage_in.shift[DATA_WIDTH-2:0], take};
    end

    assign ready_out  = !valid_reg || ready_in;
    assign valid_next = ready_out ? valid_in : valid_reg;
    assign valid_out  = valid_reg;
    assign stage_out  = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            stage_reg <= stage_next;
        end
    end

    `IDM_ASSERT_SAME(a_partial_below_divisor,
        valid_reg && (stage_reg.divisor != '0), stage_reg.partial < stage_reg.divisor,
        "Partial remainder is not below the divisor.")
    `IDM_ASSERT_NEXT(a_stall_holds, valid_reg && !ready_in,
        valid_reg && $stable(stage_reg), "Stalled item changed or vanished.")
    `IDM_ASSERT_NEXT(a_divisor_passes, valid_in && ready_out,
        valid_reg && (stage_reg.divisor == $past(stage_in.divisor)),
        "Divisor was not carried unchanged.")

endmodule

@@ hw/rtl/idm_post.sv @@
// ----------------------------------------------------------------------------
// idm_post
// Output stage: applies result signs, forces zero-divisor results, holds item.
// ----------------------------------------------------------------------------
`include "int64_divide_modulo_macros.svh"

module idm_post
    import idm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid_in,
    output logic       ready_out,
    input  idm_stage_t stage_in,
    idm_rsp_if.source  rsp
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic                  dz_reg;

    always_comb
    begin
        quo_next = stage_in.neg_quo ? ('0 - stage_in.shift) : stage_in.shift;
        rem_next = stage_in.neg_rem ? ('0 - stage_in.partial) : stage_in.partial;
        if (stage_in.div_zero)
        begin
            quo_next = '0;
            rem_next = '0;
        end
    end

    assign ready_out          = !valid_reg || rsp.ready;
    assign valid_next         = ready_out ? valid_in : valid_reg;
    assign rsp.valid          = valid_reg;
    assign rsp.quotient       = quo_reg;
    assign rsp.remainder      = rem_reg;
    assign rsp.divide_by_zero = dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            dz_reg  <= stage_in.div_zero;
        end
    end

    `IDM_ASSERT_SAME(a_zero_divisor_clears, valid_reg && dz_reg,
        (quo_reg == '0) && (rem_reg == '0), "Zero divisor left a nonzero result.")
    `IDM_ASSERT_NEXT(a_result_holds, valid_reg && !rsp.ready,
        valid_reg && $stable(quo_reg) && $stable(rem_reg) && $stable(dz_reg),
        "Waiting result changed or vanished.")
    `IDM_ASSERT_NEXT(a_load_shows, valid_in && ready_out, valid_reg,
        "Accepted item did not reach the output register.")

endmodule

@@ hw/rtl/int64_divide_modulo.sv @@
// Throughput: one item per cycle while no waiting result stalls it; the pipeline
// has one input register, one cell per quotient bit and one output register,
// each with its own valid bit.
// A waiting result stalls only the stages behind it that hold items.
// Reset clears the valid bits of all stages; payload registers are not reset.
// ----------------------------------------------------------------------------
// int64_divide_modulo
// Pipelined restoring divider giving quotient and remainder, signed or not.
// ----------------------------------------------------------------------------
module int64_divide_modulo
    import idm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    idm_req_if.sink   req,
    idm_rsp_if.source rsp
);

    logic       valid_chain [NUM_CELLS+1];
    logic       ready_chain [NUM_CELLS+1];
    idm_stage_t stage_chain [NUM_CELLS+1];

    idm_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .valid_out (valid_chain[0]),
        .ready_in  (ready_chain[0]),
        .stage_out (stage_chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        idm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[i]),
            .ready_out (ready_chain[i]),
            .stage_in  (stage_chain[i]),
            .valid_out (valid_chain[i+1]),
            .ready_in  (ready_chain[i+1]),
            .stage_out (stage_chain[i+1])
        );
    end

    idm_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_chain[NUM_CELLS]),
        .ready_out (ready_chain[NUM_CELLS]),
        .stage_in  (stage_chain[NUM_CELLS]),
        .rsp       (rsp)
    );

endmodule
